// ===== hdl/pcmm_pkg.sv =====
package pcmm_pkg;

  // sizing
  localparam int NUM_VOICES       = 64;
  localparam int BLOCK_FRAMES     = 256;
  localparam int SAMPLE_MEM_BYTES = 65536;

  localparam int VI_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int FC_W    = $clog2(BLOCK_FRAMES);
  localparam int SMEM_AW = $clog2(SAMPLE_MEM_BYTES);
  localparam int ACC_W   = 17 + VI_W;
  localparam int CFG_IW  = 2;

  // request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_PARAMS = 2'd2;
  localparam logic [1:0] REQ_MIX    = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_STARTED = 2'd1;
  localparam logic [1:0] KIND_NO_FREE = 2'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_SFX_VOLUME   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MUSIC_VOLUME = 2'd1;

  localparam logic [7:0]  VOLUME_RESET = 8'd192;
  localparam logic [15:0] STEP_UNITY   = 16'd256;
  localparam logic [15:0] STEP_MIN     = 16'd16;

  // one voice record
  typedef struct packed {
    logic [15:0] base;
    logic [16:0] len;
    logic [23:0] pos;
    logic [19:0] delay;
    logic [7:0]  gl;
    logic [7:0]  gr;
    logic [15:0] step;
  } voice_t;

  // write request to the voice store
  typedef struct packed {
    logic            en_base_len;
    logic            en_pos;
    logic            en_delay;
    logic            en_gains_step;
    logic [VI_W-1:0] addr;
    voice_t          data;
  } vwr_t;

endpackage

// ===== hdl/pcmm_voice_mem.sv =====
module pcmm_voice_mem import pcmm_pkg::*; (
  input  logic            clk,
  input  vwr_t            wr,
  input  logic [VI_W-1:0] rd_addr,
  output voice_t          rd_data
);

  logic [15:0] base_mem  [NUM_VOICES];
  logic [16:0] len_mem   [NUM_VOICES];
  logic [23:0] pos_mem   [NUM_VOICES];
  logic [19:0] delay_mem [NUM_VOICES];
  logic [7:0]  gl_mem    [NUM_VOICES];
  logic [7:0]  gr_mem    [NUM_VOICES];
  logic [15:0] step_mem  [NUM_VOICES];

  // field-group writes
  always_ff @(posedge clk) begin
    if (wr.en_base_len) begin
      base_mem[wr.addr] <= wr.data.base;
      len_mem[wr.addr]  <= wr.data.len;
    end
    if (wr.en_pos) begin
      pos_mem[wr.addr] <= wr.data.pos;
    end
    if (wr.en_delay) begin
      delay_mem[wr.addr] <= wr.data.delay;
    end
    if (wr.en_gains_step) begin
      gl_mem[wr.addr]   <= wr.data.gl;
      gr_mem[wr.addr]   <= wr.data.gr;
      step_mem[wr.addr] <= wr.data.step;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data.base  <= base_mem[rd_addr];
    rd_data.len   <= len_mem[rd_addr];
    rd_data.pos   <= pos_mem[rd_addr];
    rd_data.delay <= delay_mem[rd_addr];
    rd_data.gl    <= gl_mem[rd_addr];
    rd_data.gr    <= gr_mem[rd_addr];
    rd_data.step  <= step_mem[rd_addr];
  end

endmodule

// ===== hdl/multichannel_pcm_mixer_unit.sv =====
// Sample-voice mixer: a request is taken when start is high and busy is low; a start or mix
// request answers with one result that sits on the out_ ports for exactly one cycle with
// out_strobe high, and the receiver cannot stall it, so it must take every strobe. A sample
// write or set-params request finishes in its accept cycle. A start request scans the voice
// valid bits one channel a cycle. A mix request walks every voice
// through one shared offset/multiply path: a silent or delayed voice is skipped after its read,
// a sounding voice goes on through offset, sample fetch and accumulate, and the final gain
// and saturation close the frame; the frame that closes a block of BLOCK_FRAMES adds a pass
// over every voice for the position and delay update, after the result is given.
module multichannel_pcm_mixer_unit import pcmm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [15:0]       in_mem_addr,
  input  logic [7:0]        in_mem_byte,
  input  logic [16:0]       in_sample_len,
  input  logic [5:0]        in_chan_index,
  input  logic [7:0]        in_gain_left,
  input  logic [7:0]        in_gain_right,
  input  logic [15:0]       in_pitch_scale,
  input  logic [19:0]       in_start_delay,
  input  logic signed [15:0] in_music_sample,
  output logic              out_strobe,
  output logic [1:0]        out_result_kind,
  output logic signed [15:0] out_left_out,
  output logic signed [15:0] out_right_out,
  output logic [5:0]        out_granted_chan,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [7:0]        cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SCAN = 4'd1;
  localparam logic [3:0] ST_MRD  = 4'd2;
  localparam logic [3:0] ST_MMUL = 4'd3;
  localparam logic [3:0] ST_MOFF = 4'd4;
  localparam logic [3:0] ST_MSMP = 4'd5;
  localparam logic [3:0] ST_MACC = 4'd6;
  localparam logic [3:0] ST_FMUL = 4'd7;
  localparam logic [3:0] ST_FOUT = 4'd8;
  localparam logic [3:0] ST_ERD  = 4'd9;
  localparam logic [3:0] ST_EUPD = 4'd10;

  localparam int BS_PW = 16 + FC_W + 2;

  logic [3:0]             state_r, state_nxt;
  logic [VI_W-1:0]        vcnt_r, vcnt_nxt;
  logic [FC_W-1:0]        frame_r, frame_nxt;
  logic [NUM_VOICES-1:0]  active_r, active_nxt;
  logic [7:0]             sfx_r, music_vol_r;

  // latched request payload
  logic [15:0]            sbase_r;
  logic [16:0]            slen_r;
  logic [7:0]             sgain_r;
  logic signed [15:0]     music_r;

  // mix datapath
  logic [FC_W+15:0]       prod_r;
  logic [SMEM_AW-1:0]     smp_addr_r;
  logic [7:0]             smp_q;
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r, acc_l_nxt, acc_r_nxt;
  logic signed [ACC_W+9:0] pl_r, pr_r;
  logic signed [25:0]     pm_r;

  // result registers
  logic                   strobe_r, strobe_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic signed [15:0]     left_r, left_nxt, right_r, right_nxt;
  logic [5:0]             chan_r, chan_nxt;

  logic [7:0]             sample_mem [SAMPLE_MEM_BYTES];

  logic                   accept;
  vwr_t                   vwr;
  voice_t                 vd;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  // config only between requests
  assign cfg_ready = (state_r == ST_IDLE) && !start;

  assign out_strobe       = strobe_r;
  assign out_result_kind  = kind_r;
  assign out_left_out     = left_r;
  assign out_right_out    = right_r;
  assign out_granted_chan = chan_r;

  pcmm_voice_mem u_voice_mem (
    .clk     (clk),
    .wr      (vwr),
    .rd_addr (vcnt_r),
    .rd_data (vd)
  );

  // sample memory
  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_WRITE) begin
      sample_mem[SMEM_AW'(in_mem_addr)] <= in_mem_byte;
    end
    smp_q <= sample_mem[smp_addr_r];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sfx_r       <= VOLUME_RESET;
      music_vol_r <= VOLUME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SFX_VOLUME:   sfx_r       <= cfg_data;
        REG_MUSIC_VOLUME: music_vol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-voice arithmetic
  logic signed [8:0]      smp_s;
  logic signed [17:0]     tl, tr;
  logic [24:0]            off;
  logic [16:0]            off_c;
  logic [BS_PW-1:0]       bs_prod;
  logic [24:0]            s_w, dly_w;
  logic [19:0]            new_delay;
  logic [23:0]            new_pos;
  logic [16:0]            start_len;
  logic [15:0]            par_step;

  always_comb begin
    smp_s = $signed({1'b0, smp_q}) - 9'sd128;
    tl    = smp_s * $signed({1'b0, vd.gl});
    tr    = smp_s * $signed({1'b0, vd.gr});
    off   = 25'(vd.pos) + 25'(prod_r[FC_W+15:8]);
    off_c = (off >= 25'(vd.len)) ? (vd.len - 17'd1) : off[16:0];
    bs_prod   = BS_PW'(vd.step) * BS_PW'(BLOCK_FRAMES);
    s_w       = 25'(bs_prod >> 8);
    dly_w     = 25'(vd.delay);
    new_delay = (dly_w > s_w) ? 20'(dly_w - s_w) : 20'd0;
    new_pos   = 24'(25'(vd.pos) + s_w);
    if (in_sample_len == 17'd0) begin
      start_len = 17'd1;
    end else if (in_sample_len > 17'd65536) begin
      start_len = 17'd65536;
    end else begin
      start_len = in_sample_len;
    end
    par_step = (in_pitch_scale < STEP_MIN) ? STEP_MIN : in_pitch_scale;
  end

  // final gains and saturation
  logic signed [ACC_W+1:0] sl, sr;
  logic signed [17:0]      sm;
  logic signed [ACC_W+2:0] sum_l, sum_r;
  logic signed [15:0]      sat_l, sat_r;

  always_comb begin
    sl    = pl_r[ACC_W+9:8];
    sr    = pr_r[ACC_W+9:8];
    sm    = pm_r[25:8];
    sum_l = (ACC_W+3)'(sl) + (ACC_W+3)'(sm);
    sum_r = (ACC_W+3)'(sr) + (ACC_W+3)'(sm);
    if (sum_l > 32767) begin
      sat_l = 16'sd32767;
    end else if (sum_l < -32767) begin
      sat_l = -16'sd32767;
    end else begin
      sat_l = 16'(sum_l);
    end
    if (sum_r > 32767) begin
      sat_r = 16'sd32767;
    end else if (sum_r < -32767) begin
      sat_r = -16'sd32767;
    end else begin
      sat_r = 16'(sum_r);
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    vcnt_nxt   = vcnt_r;
    frame_nxt  = frame_r;
    active_nxt = active_r;
    acc_l_nxt  = acc_l_r;
    acc_r_nxt  = acc_r_r;
    strobe_nxt = 1'b0;
    kind_nxt   = kind_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    chan_nxt   = chan_r;
    vwr        = '0;
    vwr.addr   = vcnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_WRITE: ;
            REQ_START: begin
              vcnt_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            REQ_PARAMS: begin
              if (7'(in_chan_index) < 7'(NUM_VOICES)) begin
                vwr.addr          = VI_W'(in_chan_index);
                vwr.en_delay      = 1'b1;
                vwr.en_gains_step = 1'b1;
                vwr.data.delay    = in_start_delay;
                vwr.data.gl       = in_gain_left;
                vwr.data.gr       = in_gain_right;
                vwr.data.step     = par_step;
              end
            end
            default: begin
              vcnt_nxt  = '0;
              acc_l_nxt = '0;
              acc_r_nxt = '0;
              state_nxt = ST_MRD;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!active_r[vcnt_r]) begin
          active_nxt[vcnt_r] = 1'b1;
          vwr.en_base_len    = 1'b1;
          vwr.en_pos         = 1'b1;
          vwr.en_delay       = 1'b1;
          vwr.en_gains_step  = 1'b1;
          vwr.data.base      = sbase_r;
          vwr.data.len       = slen_r;
          vwr.data.pos       = '0;
          vwr.data.delay     = '0;
          vwr.data.gl        = sgain_r;
          vwr.data.gr        = sgain_r;
          vwr.data.step      = STEP_UNITY;
          strobe_nxt = 1'b1;
          kind_nxt   = KIND_STARTED;
          chan_nxt   = 6'(vcnt_r);
          left_nxt   = '0;
          right_nxt  = '0;
          state_nxt  = ST_IDLE;
        end else if (vcnt_r == VI_W'(NUM_VOICES - 1)) begin
          strobe_nxt = 1'b1;
          kind_nxt   = KIND_NO_FREE;
          chan_nxt   = '0;
          left_nxt   = '0;
          right_nxt  = '0;
          state_nxt  = ST_IDLE;
        end else begin
          vcnt_nxt = vcnt_r + 1'b1;
        end
      end
      ST_MRD: state_nxt = ST_MMUL;
      ST_MMUL: begin
        if (!active_r[vcnt_r] || vd.delay != 20'd0) begin
          if (vcnt_r == VI_W'(NUM_VOICES - 1)) begin
            state_nxt = ST_FMUL;
          end else begin
            vcnt_nxt  = vcnt_r + 1'b1;
            state_nxt = ST_MRD;
          end
        end else begin
          state_nxt = ST_MOFF;
        end
      end
      ST_MOFF: state_nxt = ST_MSMP;
      ST_MSMP: state_nxt = ST_MACC;
      ST_MACC: begin
        acc_l_nxt = acc_l_r + ACC_W'(tl);
        acc_r_nxt = acc_r_r + ACC_W'(tr);
        if (vcnt_r == VI_W'(NUM_VOICES - 1)) begin
          state_nxt = ST_FMUL;
        end else begin
          vcnt_nxt  = vcnt_r + 1'b1;
          state_nxt = ST_MRD;
        end
      end
      ST_FMUL: state_nxt = ST_FOUT;
      ST_FOUT: begin
        strobe_nxt = 1'b1;
        kind_nxt   = KIND_FRAME;
        chan_nxt   = '0;
        left_nxt   = sat_l;
        right_nxt  = sat_r;
        if (frame_r == FC_W'(BLOCK_FRAMES - 1)) begin
          frame_nxt = '0;
          vcnt_nxt  = '0;
          state_nxt = ST_ERD;
        end else begin
          frame_nxt = frame_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_ERD: state_nxt = ST_EUPD;
      ST_EUPD: begin
        if (active_r[vcnt_r]) begin
          if (vd.delay != 20'd0) begin
            vwr.en_delay   = 1'b1;
            vwr.data.delay = new_delay;
          end else begin
            vwr.en_pos    = 1'b1;
            vwr.data.pos  = new_pos;
            if (new_pos >= 24'(vd.len)) begin
              active_nxt[vcnt_r] = 1'b0;
            end
          end
        end
        if (vcnt_r == VI_W'(NUM_VOICES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          vcnt_nxt  = vcnt_r + 1'b1;
          state_nxt = ST_ERD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcnt_r   <= '0;
      frame_r  <= '0;
      active_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vcnt_r   <= vcnt_nxt;
      frame_r  <= frame_nxt;
      active_r <= active_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    acc_l_r <= acc_l_nxt;
    acc_r_r <= acc_r_nxt;
    kind_r  <= kind_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    chan_r  <= chan_nxt;
    if (accept) begin
      sbase_r <= in_mem_addr;
      slen_r  <= start_len;
      sgain_r <= in_gain_left;
      music_r <= in_music_sample;
    end
    if (state_r == ST_MMUL) begin
      prod_r <= (FC_W+16)'(frame_r) * (FC_W+16)'(vd.step);
    end
    if (state_r == ST_MOFF) begin
      smp_addr_r <= SMEM_AW'(vd.base) + SMEM_AW'(off_c);
    end
    if (state_r == ST_FMUL) begin
      pl_r <= acc_l_r * $signed({1'b0, sfx_r});
      pr_r <= acc_r_r * $signed({1'b0, sfx_r});
      pm_r <= music_r * $signed({1'b0, music_vol_r});
    end
  end

endmodule
